[hdl/irp_pkg.sv]
// Shared types and constants for the interval row packer.
package irp_pkg;

	// Row storage
	localparam int MAX_ROWS = 8;
	localparam int ROW_W    = 3;
	localparam int LIMIT_W  = 4;

	// Field widths
	localparam int POS_W = 16;
	localparam int GAP_W = 10;
	localparam int CFG_W = 10;
	localparam int IDX_W = 2;

	// Largest position value, used to clamp the widened end
	localparam logic signed [POS_W:0] POS_MAX = 17'sd32767;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ROW_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROW_GAP   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_WIDTH = 2'd2;

	// Reset values of the configuration registers
	localparam logic [LIMIT_W-1:0] ROW_LIMIT_RST = 4'd8;
	localparam logic [GAP_W-1:0]   ROW_GAP_RST   = 10'd48;
	localparam logic [GAP_W-1:0]   MIN_WIDTH_RST = 10'd32;

	// Interval after the end has been widened
	typedef struct packed {
		logic                    frame_start;
		logic signed [POS_W-1:0] start_pos;
		logic signed [POS_W-1:0] end_pos;
	} irp_item_t;

	// Queue handshake toward the back stage
	typedef struct packed {
		logic      valid;
		irp_item_t item;
	} irp_queue_t;

endpackage

[hdl/irp_ifs.sv]
// Channel interfaces for intervals in and row results out.
interface irp_in_if;
	logic               valid;
	logic               ready;
	logic               frame_start;
	logic signed [15:0] start_pos;
	logic signed [15:0] end_pos;

	modport source (output valid, frame_start, start_pos, end_pos, input ready);
	modport sink   (input valid, frame_start, start_pos, end_pos, output ready);
endinterface

interface irp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] row;
	logic [3:0] rows_used;
	logic       crowded;

	modport source (output valid, row, rows_used, crowded, input ready);
	modport sink   (input valid, row, rows_used, crowded, output ready);
endinterface

[hdl/irp_front.sv]
// Front stage: accepts intervals, widens the end and queues them.
module irp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	irp_in_if.sink                       in_ch,
	input  logic [irp_pkg::GAP_W-1:0]    min_width,
	output irp_pkg::irp_queue_t          q_out,
	input  logic                         q_pop
);

	logic signed [irp_pkg::POS_W:0]   lim_w;
	logic signed [irp_pkg::POS_W:0]   end_w;
	logic signed [irp_pkg::POS_W:0]   wide_w;
	irp_pkg::irp_item_t               item_w;
	logic                             push;
	irp_pkg::irp_item_t               mem_q [irp_pkg::QDEPTH];
	logic [irp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [irp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [irp_pkg::QCNT_W-1:0]       count_q;

	// Widen the end to at least start plus minimum width, clamp to the position range
	always_comb begin
		lim_w  = $signed({in_ch.start_pos[irp_pkg::POS_W-1], in_ch.start_pos})
			+ $signed({1'b0, {(irp_pkg::POS_W - irp_pkg::GAP_W){1'b0}}, min_width});
		end_w  = $signed({in_ch.end_pos[irp_pkg::POS_W-1], in_ch.end_pos});
		wide_w = (end_w < lim_w) ? lim_w : end_w;
		item_w.frame_start = in_ch.frame_start;
		item_w.start_pos   = in_ch.start_pos;
		if (wide_w > irp_pkg::POS_MAX) begin
			item_w.end_pos = irp_pkg::POS_MAX[irp_pkg::POS_W-1:0];
		end else begin
			item_w.end_pos = wide_w[irp_pkg::POS_W-1:0];
		end
	end

	assign in_ch.ready = (count_q != irp_pkg::QCNT_W'(irp_pkg::QDEPTH));
	assign push        = in_ch.valid & in_ch.ready;

	// Hold queued beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_w;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_out.valid = (count_q != '0);
	assign q_out.item  = mem_q[rd_ptr_q];

endmodule

[hdl/irp_back.sv]
// Back stage: places each queued interval on a row and registers the result.
module irp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  irp_pkg::irp_queue_t           q_in,
	output logic                          q_pop,
	input  logic [irp_pkg::LIMIT_W-1:0]   row_limit,
	input  logic [irp_pkg::GAP_W-1:0]     row_gap,
	irp_out_if.source                     out_ch
);

	logic signed [irp_pkg::POS_W-1:0] row_end_q [irp_pkg::MAX_ROWS];
	logic [irp_pkg::MAX_ROWS-1:0]     row_busy_q;
	logic [irp_pkg::LIMIT_W-1:0]      used_q;
	logic                             crowd_q;
	logic                             out_valid_q;
	logic [irp_pkg::ROW_W-1:0]        out_row_q;
	logic [irp_pkg::LIMIT_W-1:0]      out_used_q;
	logic                             out_crowd_q;

	logic [irp_pkg::LIMIT_W-1:0]      nrows;
	logic [irp_pkg::MAX_ROWS-1:0]     busy_eff;
	logic [irp_pkg::MAX_ROWS-1:0]     in_range;
	logic [irp_pkg::MAX_ROWS-1:0]     fit;
	logic signed [irp_pkg::POS_W+1:0] start_x;
	logic signed [irp_pkg::POS_W+1:0] thr [irp_pkg::MAX_ROWS];
	logic                             found;
	logic [irp_pkg::ROW_W-1:0]        first_idx;
	logic [irp_pkg::ROW_W-1:0]        min_idx;
	logic [irp_pkg::ROW_W-1:0]        best;
	logic [irp_pkg::LIMIT_W-1:0]      used_base;
	logic [irp_pkg::LIMIT_W-1:0]      best_cnt;
	logic [irp_pkg::LIMIT_W-1:0]      used_next;
	logic                             crowd_next;

	// Take a beat when the output register is free or being drained
	assign q_pop = q_in.valid & (~out_valid_q | out_ch.ready);

	// Clamp the row limit into one to the row count
	always_comb begin
		if (row_limit == '0) begin
			nrows = irp_pkg::LIMIT_W'(1);
		end else if (row_limit > irp_pkg::LIMIT_W'(irp_pkg::MAX_ROWS)) begin
			nrows = irp_pkg::LIMIT_W'(irp_pkg::MAX_ROWS);
		end else begin
			nrows = row_limit;
		end
	end

	// Test every row for a fit at full precision
	always_comb begin
		start_x  = $signed({{2{q_in.item.start_pos[irp_pkg::POS_W-1]}}, q_in.item.start_pos});
		busy_eff = q_in.item.frame_start ? '0 : row_busy_q;
		for (int r = 0; r < irp_pkg::MAX_ROWS; r++) begin
			thr[r] = $signed({{2{row_end_q[r][irp_pkg::POS_W-1]}}, row_end_q[r]})
				+ $signed({{(irp_pkg::POS_W + 2 - irp_pkg::GAP_W){1'b0}}, row_gap});
			in_range[r] = (irp_pkg::LIMIT_W'(r) < nrows);
			fit[r]      = in_range[r] & (~busy_eff[r] | (start_x >= thr[r]));
		end
	end

	// Pick the first fitting row, else the earliest-freeing row in range
	always_comb begin
		found     = 1'b0;
		first_idx = '0;
		for (int r = 0; r < irp_pkg::MAX_ROWS; r++) begin
			if (fit[r] && !found) begin
				found     = 1'b1;
				first_idx = irp_pkg::ROW_W'(r);
			end
		end
		min_idx = '0;
		for (int r = 1; r < irp_pkg::MAX_ROWS; r++) begin
			if (in_range[r] && (row_end_q[r] < row_end_q[min_idx])) begin
				min_idx = irp_pkg::ROW_W'(r);
			end
		end
		best = found ? first_idx : min_idx;
	end

	// Frame totals after this placement
	always_comb begin
		used_base  = q_in.item.frame_start ? '0 : used_q;
		best_cnt   = irp_pkg::LIMIT_W'(best) + irp_pkg::LIMIT_W'(1);
		used_next  = (best_cnt > used_base) ? best_cnt : used_base;
		crowd_next = (q_in.item.frame_start ? 1'b0 : crowd_q) | ~found;
	end

	// Store the row end of the chosen row and register the output fields
	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_end_q[best] <= q_in.item.end_pos;
			out_row_q       <= best;
			out_used_q      <= used_next;
			out_crowd_q     <= crowd_next;
		end
	end

	// Update frame state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_busy_q  <= '0;
			used_q      <= '0;
			crowd_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				row_busy_q  <= busy_eff | (irp_pkg::MAX_ROWS'(1) << best);
				used_q      <= used_next;
				crowd_q     <= crowd_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.row       = out_row_q;
	assign out_ch.rows_used = out_used_q;
	assign out_ch.crowded   = out_crowd_q;

endmodule

[hdl/interval_row_packer.sv]
// Interval row packer: one interval per clock, sustained while out_ch takes
// each result. An interval accepted on in_ch gets its end widened and enters
// a two-beat queue on that edge; the back stage takes it from the queue,
// places it on the first row that is free or clear of its last end plus
// row_gap (or on the earliest-freeing row, flagging the frame crowded) and
// registers the result, which out_ch then shows until it is taken. That
// placement, made combinationally from the row state the previous interval
// left, sets the rate. A result waiting on out_ch does not stop new intervals:
// they collect in the queue until it is full. Write the configuration
// registers only while the block is idle.
module interval_row_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [irp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [irp_pkg::CFG_W-1:0]    cfg_data,
	irp_in_if.sink                       in_ch,
	irp_out_if.source                    out_ch
);

	logic [irp_pkg::LIMIT_W-1:0] row_limit_q;
	logic [irp_pkg::GAP_W-1:0]   row_gap_q;
	logic [irp_pkg::GAP_W-1:0]   min_width_q;
	irp_pkg::irp_queue_t         q_data;
	logic                        q_pop;

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_limit_q <= irp_pkg::ROW_LIMIT_RST;
			row_gap_q   <= irp_pkg::ROW_GAP_RST;
			min_width_q <= irp_pkg::MIN_WIDTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				irp_pkg::REG_ROW_LIMIT: row_limit_q <= cfg_data[irp_pkg::LIMIT_W-1:0];
				irp_pkg::REG_ROW_GAP:   row_gap_q   <= cfg_data[irp_pkg::GAP_W-1:0];
				irp_pkg::REG_MIN_WIDTH: min_width_q <= cfg_data[irp_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	irp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.min_width (min_width_q),
		.q_out     (q_data),
		.q_pop     (q_pop)
	);

	irp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_in      (q_data),
		.q_pop     (q_pop),
		.row_limit (row_limit_q),
		.row_gap   (row_gap_q),
		.out_ch    (out_ch)
	);

endmodule

[tb/sv/tb_interval_row_packer.sv]
// Self-checking testbench for the interval row packer: predicted row placement per interval.
module tb_interval_row_packer;
	timeunit 1ns;
	timeprecision 1ps;

	import irp_pkg::*;

	// Interval as sent on the input channel
	typedef struct {
		bit                      frame_start;
		logic signed [POS_W-1:0] start_pos;
		logic signed [POS_W-1:0] end_pos;
	} interval_t;

	// Placement expected on the output channel
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [LIMIT_W-1:0] rows_used;
		logic               crowded;
	} placement_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	irp_in_if  in_ch ();
	irp_out_if out_ch ();

	interval_row_packer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow copy of the configuration and the row state
	logic [LIMIT_W-1:0] row_limit_cfg;
	logic [GAP_W-1:0]   row_gap_cfg;
	logic [GAP_W-1:0]   min_width_cfg;
	int                 lane_end [MAX_ROWS];
	bit                 lane_busy [MAX_ROWS];
	int                 lane_peak;
	bit                 lane_crowd;

	interval_t  interval_q [$];
	placement_t placement_q [$];
	int         n_fail;
	int         in_gap;
	int         out_stall;
	bit         in_calm;
	bit         out_calm;

	// Empty every row and the frame flags
	function automatic void clear_lanes();
		for (int r = 0; r < MAX_ROWS; r++) begin
			lane_end[r] = 0;
			lane_busy[r] = 1'b0;
		end
		lane_peak = 0;
		lane_crowd = 1'b0;
	endfunction

	// Place one interval on the shadow rows and return the expected result
	function automatic placement_t place_interval(interval_t it);
		int         s;
		int         e;
		int         lim;
		int         nrows;
		int         best;
		placement_t res;
		if (it.frame_start)
			clear_lanes();
		s = it.start_pos;
		e = it.end_pos;
		lim = s + int'(min_width_cfg);
		if (e < lim)
			e = lim;
		if (e > 32767)
			e = 32767;
		nrows = int'(row_limit_cfg);
		if (nrows < 1)
			nrows = 1;
		if (nrows > MAX_ROWS)
			nrows = MAX_ROWS;
		// first row that is empty or clear of its last end plus the gap
		best = -1;
		for (int r = 0; r < nrows; r++) begin
			if (best < 0 && (!lane_busy[r] || s >= lane_end[r] + int'(row_gap_cfg)))
				best = r;
		end
		// all busy: share the row that frees soonest
		if (best < 0) begin
			best = 0;
			for (int r = 1; r < nrows; r++) begin
				if (lane_end[r] < lane_end[best])
					best = r;
			end
			lane_crowd = 1'b1;
		end
		lane_end[best] = e;
		lane_busy[best] = 1'b1;
		if (best + 1 > lane_peak)
			lane_peak = best + 1;
		res.row = best[ROW_W-1:0];
		res.rows_used = lane_peak[LIMIT_W-1:0];
		res.crowded = lane_crowd;
		return res;
	endfunction

	// Idle length: mostly short, now and then long
	function automatic int draw_gap(bit calm);
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(int v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[POS_W-1:0];
	endfunction

	function automatic void push_interval(bit fs, int s, int e);
		interval_t it;
		it.frame_start = fs;
		it.start_pos = sat_pos(s);
		it.end_pos = sat_pos(e);
		interval_q.push_back(it);
	endfunction

	// One frame of intervals in start order, with random density and widths
	function automatic void push_frame(int n, bit fresh);
		int pos;
		int dens;
		int span;
		int len;
		pos = $urandom_range(0, 65535) - 32768;
		dens = $urandom_range(1, 8);
		span = (int'(row_gap_cfg) + int'(min_width_cfg) + 64) * 2 / dens;
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				pos = pos + $urandom_range(0, span);
			if (pos > 32767)
				pos = 32767;
			if ($urandom_range(0, 4) == 0)
				len = -$urandom_range(0, 500);
			else
				len = $urandom_range(0, 1500);
			push_interval(i == 0 && fresh, pos, pos + len);
		end
	endfunction

	// Random content for a phase: mostly frames, some noise
	function automatic void push_phase(int count);
		int added;
		int n;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) == 0) begin
				push_interval(1'($urandom_range(0, 1)), $urandom_range(0, 65535) - 32768,
					$urandom_range(0, 65535) - 32768);
				added++;
			end else begin
				n = $urandom_range(1, 40);
				push_frame(n, $urandom_range(0, 99) >= 15);
				added += n;
			end
		end
	endfunction

	// Write one register and track it in the shadow copy
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ROW_LIMIT: row_limit_cfg = val[LIMIT_W-1:0];
			REG_ROW_GAP:   row_gap_cfg = val[GAP_W-1:0];
			REG_MIN_WIDTH: min_width_cfg = val[GAP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Hold until every interval is sent and every placement has come back
	task automatic wait_idle();
		while (interval_q.size() != 0 || in_ch.valid || placement_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Input driver: present the next pending interval after a random gap
	always @(posedge clk) begin : drv_proc
		interval_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				it.frame_start = in_ch.frame_start;
				it.start_pos = in_ch.start_pos;
				it.end_pos = in_ch.end_pos;
				placement_q.push_back(place_interval(it));
				in_gap = draw_gap(in_calm);
				if ($urandom_range(0, 149) == 0)
					in_calm = ~in_calm;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (interval_q.size() != 0) begin
					it = interval_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.frame_start <= it.frame_start;
					in_ch.start_pos <= it.start_pos;
					in_ch.end_pos <= it.end_pos;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each beat against the oldest placement, stall at random
	always @(posedge clk) begin : mon_proc
		placement_t want;
		int         stall_n;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			stall_n = out_stall;
			if (out_ch.valid && out_ch.ready) begin
				if (placement_q.size() == 0) begin
					$error("unexpected result beat: row %0d rows_used %0d crowded %0d",
						out_ch.row, out_ch.rows_used, out_ch.crowded);
					n_fail++;
				end else begin
					want = placement_q.pop_front();
					if (out_ch.row !== want.row) begin
						$error("row: expected %0d, got %0d", want.row, out_ch.row);
						n_fail++;
					end
					if (out_ch.rows_used !== want.rows_used) begin
						$error("rows_used: expected %0d, got %0d", want.rows_used,
							out_ch.rows_used);
						n_fail++;
					end
					if (out_ch.crowded !== want.crowded) begin
						$error("crowded: expected %0d, got %0d", want.crowded, out_ch.crowded);
						n_fail++;
					end
				end
				stall_n = draw_gap(out_calm);
				if ($urandom_range(0, 149) == 0)
					out_calm = ~out_calm;
			end
			if (stall_n > 0) begin
				out_ch.ready <= 1'b0;
				out_stall <= stall_n - 1;
			end else begin
				out_ch.ready <= 1'b1;
				out_stall <= 0;
			end
		end
	end

	initial begin : main_proc
		int lim_tab [5] = '{0, 1, 15, 9, 8};
		int gap_tab [5] = '{0, 1023, 48, 0, 1023};
		int mw_tab [5]  = '{0, 1023, 32, 1023, 0};
		n_fail = 0;
		in_gap = 0;
		out_stall = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.frame_start = 1'b0;
		in_ch.start_pos = '0;
		in_ch.end_pos = '0;
		out_ch.ready = 1'b0;
		row_limit_cfg = ROW_LIMIT_RST;
		row_gap_cfg = ROW_GAP_RST;
		min_width_cfg = MIN_WIDTH_RST;
		clear_lanes();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: continue from reset state, position extremes, saturation
		push_interval(1'b0, 0, 0);
		push_interval(1'b0, 16, 16);
		push_interval(1'b1, -32768, -32768);
		push_interval(1'b0, -32768, 32767);
		push_interval(1'b0, 32767, 32767);
		push_interval(1'b0, 32767, -32768);
		push_interval(1'b0, 32760, 0);
		// Directed: fill every row, then crowd with ties
		for (int i = 0; i < 10; i++)
			push_interval(i == 0, 100, 200);
		push_interval(1'b1, 0, 0);
		push_interval(1'b0, 80, -5);
		push_interval(1'b0, 81, 120);
		wait_idle();

		// Phases: extreme settings first, then random ones
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 5) begin
				write_reg(REG_ROW_LIMIT, {6'($urandom_range(0, 63)), lim_tab[ph][3:0]});
				write_reg(REG_ROW_GAP, gap_tab[ph][CFG_W-1:0]);
				write_reg(REG_MIN_WIDTH, mw_tab[ph][CFG_W-1:0]);
			end else begin
				write_reg(REG_ROW_LIMIT, CFG_W'($urandom_range(0, 1023)));
				write_reg(REG_ROW_GAP, CFG_W'($urandom_range(0, 1023)));
				write_reg(REG_MIN_WIDTH, CFG_W'($urandom_range(0, 1023)));
			end
			// unknown index: must leave all registers alone
			if (ph == 0 || ph == 7)
				write_reg(2'd3, CFG_W'($urandom_range(0, 1023)));
			push_phase(200);
			wait_idle();
		end

		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
hdl/irp_pkg.sv
hdl/irp_ifs.sv
hdl/irp_front.sv
hdl/irp_back.sv
hdl/interval_row_packer.sv
tb/sv/tb_interval_row_packer.sv
